// ===== rtl/cctl_pkg.sv =====
// ----------------------------------------------------------------------------
// cctl_pkg
// Shared sizes, codes and helpers for the configuration cache tag lookup.
// ----------------------------------------------------------------------------
package cctl_pkg;

  localparam int NUM_CONTEXTS = 4;
  localparam int NUM_ROWS     = 32;
  localparam int STORE_DEPTH  = NUM_CONTEXTS * NUM_ROWS;

  localparam int TAG_W   = 32;
  localparam int FIELD_W = 6;
  localparam int ROW_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CTX_W   = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int ENTRY_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  // holds start + offset (up to 126) and NUM_ROWS itself
  localparam int POS_W   = $clog2(((NUM_ROWS > 127) ? NUM_ROWS : 127) + 1);
  // sum of NUM_ROWS stamps never overflows this
  localparam int SUM_W   = TAG_W + ROW_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [TAG_W-1:0] TAG_CONT    = 32'hFFFF_FFFF;
  localparam logic [TAG_W-1:0] TAG_INVALID = 32'hFFFF_FFFE;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOC_START = 1'b0,
    CFG_ALLOC_END   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT_WR,
    ST_MISS_WR,
    ST_AFTER_RD,
    ST_AFTER_WR,
    ST_FINISH
  } state_t;

  function automatic logic [ENTRY_W-1:0] entry_of(logic [CTX_W-1:0] ctx,
                                                  logic [POS_W-1:0] row);
    entry_of = ENTRY_W'(ENTRY_W'(ctx) * ENTRY_W'(NUM_ROWS) + ENTRY_W'(row));
  endfunction

endpackage

// ===== rtl/config_cache_tag_lookup_lru.sv =====
// ----------------------------------------------------------------------------
// config_cache_tag_lookup_lru
// Tag and stamp store of a multi-context configuration cache with
// least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, config_address,           | sink
//          | row_offset, row_count                        |
//  out     | out_valid/out_ready, load_needed, context_res| source
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data     | sink
//
//  One word at a time. An out-of-range word goes straight to the result. Else
//  the run is read context by context, one row a cycle, through the single
//  read port of the tag/stamp memories. A hit stops the scan and refreshes
//  the run's stamps; a miss scans every context and writes the run into the
//  one with the smallest stamp sum. Reset (rst, synchronous) clears the
//  per-entry valid bits at once; no clearing pass. A stalled result sits in
//  the output register while the next word is taken.
// ----------------------------------------------------------------------------
module config_cache_tag_lookup_lru (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cctl_pkg::TAG_W-1:0]         config_address,
  input  logic [cctl_pkg::FIELD_W-1:0]       row_offset,
  input  logic [cctl_pkg::FIELD_W-1:0]       row_count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               load_needed,
  output logic [1:0]                         context_res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cctl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cctl_pkg::FIELD_W-1:0]       cfg_data
);

  localparam int TAG_W   = cctl_pkg::TAG_W;
  localparam int FIELD_W = cctl_pkg::FIELD_W;
  localparam int POS_W   = cctl_pkg::POS_W;
  localparam int CTX_W   = cctl_pkg::CTX_W;
  localparam int ENTRY_W = cctl_pkg::ENTRY_W;
  localparam int SUM_W   = cctl_pkg::SUM_W;
  localparam int DEPTH   = cctl_pkg::STORE_DEPTH;

  cctl_pkg::state_t state, state_next;

  logic [FIELD_W-1:0] alloc_start_row, alloc_end_row;
  logic [TAG_W-1:0]   load_counter, tag_req;
  logic [POS_W-1:0]   start_row;
  logic [FIELD_W-1:0] run_count, run_len;
  logic [CTX_W-1:0]   issue_ctx, proc_ctx, chosen;
  logic [FIELD_W-1:0] issue_row, proc_row, wr_row;
  logic               issue_done, rd_vld;
  logic               match_acc, cont_acc, res_load;
  logic [SUM_W-1:0]   sum_acc, best_sum;

  // memories
  logic [TAG_W-1:0]   tag_mem   [DEPTH];
  logic [TAG_W-1:0]   stamp_mem [DEPTH];
  logic [DEPTH-1:0]   tag_vld, stamp_vld;
  logic [TAG_W-1:0]   tag_raw, stamp_raw, tag_rd, stamp_rd;
  logic               tag_rv, stamp_rv;
  logic [ENTRY_W-1:0] rd_entry, tag_wa, stamp_wa;
  logic [TAG_W-1:0]   tag_wd;
  logic               tag_we, stamp_we;

  // request decode
  logic [POS_W-1:0]   end_row, req_start, span;
  logic               out_of_range, in_acc;
  logic [FIELD_W-1:0] req_count;

  // scan datapath
  logic               proc_first, proc_last, proc_end, proc_hit, proc_better, last_ctx;
  logic               match_now, cont_now;
  logic [SUM_W-1:0]   stamp_add, sum_now;
  logic [POS_W-1:0]   after_row;
  logic               after_ok;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  assign end_row = (POS_W'(alloc_end_row) > POS_W'(cctl_pkg::NUM_ROWS)) ?
                   POS_W'(cctl_pkg::NUM_ROWS) : POS_W'(alloc_end_row);
  assign req_start    = POS_W'(alloc_start_row) + POS_W'(row_offset);
  assign out_of_range = (req_start > end_row) || (req_start >= POS_W'(cctl_pkg::NUM_ROWS));
  assign span         = end_row - req_start;
  assign req_count    = (POS_W'(row_count) > span) ? FIELD_W'(span) : row_count;

  // unwritten entries read as their reset value
  assign tag_rd   = tag_rv   ? tag_raw   : cctl_pkg::TAG_INVALID;
  assign stamp_rd = stamp_rv ? stamp_raw : '0;

  assign proc_first  = (proc_row == '0);
  assign proc_last   = (proc_row == run_len - FIELD_W'(1));
  assign stamp_add   = (proc_row < run_count) ? SUM_W'(stamp_rd) : '0;
  assign sum_now     = (proc_first ? '0 : sum_acc) + stamp_add;
  assign match_now   = proc_first ? (tag_rd == tag_req) : match_acc;
  assign cont_now    = proc_first || (cont_acc && tag_rd[0]);
  assign proc_end    = (state == cctl_pkg::ST_SCAN) && rd_vld && proc_last;
  assign proc_hit    = proc_end && match_now && cont_now;
  assign proc_better = (proc_ctx == '0) || (sum_now < best_sum);
  assign last_ctx    = (proc_ctx == CTX_W'(cctl_pkg::NUM_CONTEXTS - 1));
  assign after_row   = start_row + POS_W'(run_len);
  assign after_ok    = (after_row < POS_W'(cctl_pkg::NUM_ROWS));

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_entry   = cctl_pkg::entry_of(issue_ctx, start_row + POS_W'(issue_row));
    tag_we     = 1'b0;
    stamp_we   = 1'b0;
    tag_wa     = cctl_pkg::entry_of(chosen, start_row + POS_W'(wr_row));
    stamp_wa   = tag_wa;
    tag_wd     = (wr_row == '0) ? tag_req : cctl_pkg::TAG_CONT;
    unique case (state)
      cctl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = out_of_range ? cctl_pkg::ST_FINISH : cctl_pkg::ST_SCAN;
        end
      end
      cctl_pkg::ST_SCAN: begin
        if (proc_hit) begin
          state_next = (run_count == '0) ? cctl_pkg::ST_FINISH : cctl_pkg::ST_HIT_WR;
        end else if (proc_end && last_ctx) begin
          state_next = cctl_pkg::ST_MISS_WR;
        end
      end
      cctl_pkg::ST_HIT_WR: begin
        stamp_we = 1'b1;
        if (wr_row == run_count - FIELD_W'(1)) begin
          state_next = cctl_pkg::ST_FINISH;
        end
      end
      cctl_pkg::ST_MISS_WR: begin
        tag_we   = 1'b1;
        stamp_we = 1'b1;
        if (wr_row == run_len - FIELD_W'(1)) begin
          state_next = after_ok ? cctl_pkg::ST_AFTER_RD : cctl_pkg::ST_FINISH;
        end
      end
      cctl_pkg::ST_AFTER_RD: begin
        rd_entry   = cctl_pkg::entry_of(chosen, after_row);
        state_next = cctl_pkg::ST_AFTER_WR;
      end
      cctl_pkg::ST_AFTER_WR: begin
        // a stray continuation row after the run is knocked back to invalid
        tag_wa     = cctl_pkg::entry_of(chosen, after_row);
        tag_wd     = cctl_pkg::TAG_INVALID;
        tag_we     = tag_rd[0];
        state_next = cctl_pkg::ST_FINISH;
      end
      cctl_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = cctl_pkg::ST_IDLE;
        end
      end
      default: state_next = cctl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cctl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_start_row <= '0;
      alloc_end_row   <= FIELD_W'(32);
      load_counter    <= '0;
      out_valid       <= 1'b0;
      rd_vld          <= 1'b0;
      issue_done      <= 1'b0;
      tag_vld         <= '0;
      stamp_vld       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cctl_pkg::cfg_reg_t'(cfg_index))
          cctl_pkg::CFG_ALLOC_START: alloc_start_row <= cfg_data;
          cctl_pkg::CFG_ALLOC_END:   alloc_end_row   <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && !out_of_range) begin
        load_counter <= load_counter + TAG_W'(1);
      end
      if (state == cctl_pkg::ST_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      rd_vld <= (state == cctl_pkg::ST_SCAN) && !issue_done;
      if (in_acc) begin
        issue_done <= 1'b0;
      end else if (state == cctl_pkg::ST_SCAN && !issue_done &&
                   issue_row == run_len - FIELD_W'(1) &&
                   issue_ctx == CTX_W'(cctl_pkg::NUM_CONTEXTS - 1)) begin
        issue_done <= 1'b1;
      end
      if (tag_we) begin
        tag_vld[tag_wa] <= 1'b1;
      end
      if (stamp_we) begin
        stamp_vld[stamp_wa] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_req   <= config_address;
      start_row <= req_start;
      run_count <= req_count;
      run_len   <= (req_count == '0) ? FIELD_W'(1) : req_count;
      issue_ctx <= '0;
      issue_row <= '0;
      chosen    <= '0;
      res_load  <= !out_of_range;
    end else if (state == cctl_pkg::ST_SCAN && !issue_done) begin
      if (issue_row == run_len - FIELD_W'(1)) begin
        issue_row <= '0;
        issue_ctx <= issue_ctx + CTX_W'(1);
      end else begin
        issue_row <= issue_row + FIELD_W'(1);
      end
    end
    proc_ctx <= issue_ctx;
    proc_row <= issue_row;
    if (state == cctl_pkg::ST_SCAN && rd_vld) begin
      sum_acc   <= sum_now;
      match_acc <= match_now;
      cont_acc  <= cont_now;
      if (proc_hit) begin
        chosen   <= proc_ctx;
        res_load <= 1'b0;
      end else if (proc_end && proc_better) begin
        best_sum <= sum_now;
        chosen   <= proc_ctx;
      end
    end
    if (state == cctl_pkg::ST_HIT_WR || state == cctl_pkg::ST_MISS_WR) begin
      wr_row <= wr_row + FIELD_W'(1);
    end else begin
      wr_row <= '0;
    end
    if (state == cctl_pkg::ST_FINISH && (!out_valid || out_ready)) begin
      load_needed <= res_load;
      context_res <= 2'(chosen);
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= load_counter;
    end
    tag_raw   <= tag_mem[rd_entry];
    stamp_raw <= stamp_mem[rd_entry];
    tag_rv    <= tag_vld[rd_entry];
    stamp_rv  <= stamp_vld[rd_entry];
  end

endmodule

// ===== rtl/cctl_checker.sv =====
// ----------------------------------------------------------------------------
// cctl_checker
// Port-level checks for the configuration cache tag lookup.
// ----------------------------------------------------------------------------
module cctl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       load_needed,
  input logic [1:0] context_res
);

  // one word in flight: busy straight after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // a result only appears while a lookup is under way
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a lookup");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(load_needed) && $stable(context_res)))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind config_cache_tag_lookup_lru cctl_checker u_cctl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .load_needed (load_needed),
  .context_res (context_res)
);
